@@ sv/yuyv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// yuyv2rgb_pkg
// Shared types, register codes and arithmetic helpers for the YUYV to RGB
// pixel converter.
// ----------------------------------------------------------------------------
package yuyv2rgb_pkg;

  localparam int COEF_W  = 10;
  localparam int BYTE_W  = 8;
  localparam int TERM_W  = 20;
  localparam int SUM_W   = 21;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [1:0] REG_COEF_V_RED   = 2'd0;
  localparam logic [1:0] REG_COEF_U_GREEN = 2'd1;
  localparam logic [1:0] REG_COEF_V_GREEN = 2'd2;
  localparam logic [1:0] REG_COEF_U_BLUE  = 2'd3;

  localparam logic [COEF_W-1:0] RST_COEF_V_RED   = 10'd359;
  localparam logic [COEF_W-1:0] RST_COEF_U_GREEN = 10'd88;
  localparam logic [COEF_W-1:0] RST_COEF_V_GREEN = 10'd183;
  localparam logic [COEF_W-1:0] RST_COEF_U_BLUE  = 10'd454;

  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

  typedef struct packed {
    logic [BYTE_W-1:0] luma_first;
    logic [BYTE_W-1:0] chroma_u;
    logic [BYTE_W-1:0] luma_second;
    logic [BYTE_W-1:0] chroma_v;
  } pix_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first_px_chan0;
    logic [BYTE_W-1:0] first_px_green;
    logic [BYTE_W-1:0] first_px_chan2;
    logic [BYTE_W-1:0] second_px_chan0;
    logic [BYTE_W-1:0] second_px_green;
    logic [BYTE_W-1:0] second_px_chan2;
  } pix_out_t;

  typedef struct packed {
    logic [COEF_W-1:0] coef_v_red;
    logic [COEF_W-1:0] coef_u_green;
    logic [COEF_W-1:0] coef_v_green;
    logic [COEF_W-1:0] coef_u_blue;
  } coef_set_t;

  // offset binary to two's complement: value minus 128
  function automatic logic signed [BYTE_W:0] centre_chroma(input logic [BYTE_W-1:0] c);
    centre_chroma = $signed({~c[BYTE_W-1], ~c[BYTE_W-1], c[BYTE_W-2:0]});
  endfunction

  function automatic logic signed [TERM_W-1:0] chroma_term(
    input logic [COEF_W-1:0]        coef,
    input logic signed [BYTE_W:0]   c
  );
    logic signed [COEF_W:0] coef_s;
    coef_s      = $signed({1'b0, coef});
    chroma_term = coef_s * c;
  endfunction

  function automatic logic signed [SUM_W-1:0] luma_scaled(input logic [BYTE_W-1:0] y);
    luma_scaled = $signed({{(SUM_W-BYTE_W-8){1'b0}}, y, 8'd0});
  endfunction

  // floor divide by 256, clamp to byte range
  function automatic logic [BYTE_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] s);
    if (s[SUM_W-1]) begin
      clamp_channel = '0;
    end else if (s[SUM_W-2:16] != '0) begin
      clamp_channel = BYTE_MAX;
    end else begin
      clamp_channel = s[15:8];
    end
  endfunction

endpackage

@@ sv/yuyv2rgb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// yuyv2rgb_cfg_regs
// APB-style register file holding the four conversion gains.
// ----------------------------------------------------------------------------
module yuyv2rgb_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [yuyv2rgb_pkg::ADDR_W-1:0]     paddr,
  input  logic [yuyv2rgb_pkg::DATA_W-1:0]     pwdata,
  output logic [yuyv2rgb_pkg::DATA_W-1:0]     prdata,
  output logic                                pready,
  output yuyv2rgb_pkg::coef_set_t             coefs
);
  import yuyv2rgb_pkg::*;

  coef_set_t   coefs_r;
  coef_set_t   coefs_nxt;
  logic        wr_en;
  logic [1:0]  reg_sel;
  logic [COEF_W-1:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_comb begin
    coefs_nxt = coefs_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_COEF_V_RED:   coefs_nxt.coef_v_red   = pwdata[COEF_W-1:0];
        REG_COEF_U_GREEN: coefs_nxt.coef_u_green = pwdata[COEF_W-1:0];
        REG_COEF_V_GREEN: coefs_nxt.coef_v_green = pwdata[COEF_W-1:0];
        REG_COEF_U_BLUE:  coefs_nxt.coef_u_blue  = pwdata[COEF_W-1:0];
        default:          coefs_nxt = coefs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.coef_v_red   <= RST_COEF_V_RED;
      coefs_r.coef_u_green <= RST_COEF_U_GREEN;
      coefs_r.coef_v_green <= RST_COEF_V_GREEN;
      coefs_r.coef_u_blue  <= RST_COEF_U_BLUE;
    end else begin
      coefs_r <= coefs_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COEF_V_RED:   rd_val = coefs_r.coef_v_red;
      REG_COEF_U_GREEN: rd_val = coefs_r.coef_u_green;
      REG_COEF_V_GREEN: rd_val = coefs_r.coef_v_green;
      REG_COEF_U_BLUE:  rd_val = coefs_r.coef_u_blue;
      default:          rd_val = '0;
    endcase
  end

  assign prdata = {{(DATA_W-COEF_W){1'b0}}, rd_val};
  assign coefs  = coefs_r;

endmodule

@@ sv/yuyv2rgb_datapath.sv @@
// ----------------------------------------------------------------------------
// yuyv2rgb_datapath
// Input register, chroma gain products, channel sums with clamp, and the
// result register.
// ----------------------------------------------------------------------------
module yuyv2rgb_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_take,
  input  yuyv2rgb_pkg::pix_in_t     in_data,
  input  yuyv2rgb_pkg::coef_set_t   coefs,
  output logic                      out_valid,
  output yuyv2rgb_pkg::pix_out_t    out_data
);
  import yuyv2rgb_pkg::*;

  logic      in_vld_r;
  pix_in_t   in_r;
  logic      out_vld_r;
  pix_out_t  out_r;
  pix_out_t  out_nxt;

  logic signed [BYTE_W:0]   cu;
  logic signed [BYTE_W:0]   cv;
  logic signed [TERM_W-1:0] t_vr;
  logic signed [TERM_W-1:0] t_ug;
  logic signed [TERM_W-1:0] t_vg;
  logic signed [TERM_W-1:0] t_ub;
  logic signed [SUM_W-1:0]  y0;
  logic signed [SUM_W-1:0]  y1;
  logic signed [SUM_W-1:0]  g_term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
  end

  always_comb begin
    cu     = centre_chroma(in_r.chroma_u);
    cv     = centre_chroma(in_r.chroma_v);
    t_vr   = chroma_term(coefs.coef_v_red,   cv);
    t_ug   = chroma_term(coefs.coef_u_green, cu);
    t_vg   = chroma_term(coefs.coef_v_green, cv);
    t_ub   = chroma_term(coefs.coef_u_blue,  cu);
    y0     = luma_scaled(in_r.luma_first);
    y1     = luma_scaled(in_r.luma_second);
    g_term = SUM_W'(t_ug) + SUM_W'(t_vg);

    out_nxt.first_px_chan0  = clamp_channel(y0 + SUM_W'(t_vr));
    out_nxt.first_px_green  = clamp_channel(y0 - g_term);
    out_nxt.first_px_chan2  = clamp_channel(y0 + SUM_W'(t_ub));
    out_nxt.second_px_chan0 = clamp_channel(y1 + SUM_W'(t_vr));
    out_nxt.second_px_green = clamp_channel(y1 - g_term);
    out_nxt.second_px_chan2 = clamp_channel(y1 + SUM_W'(t_ub));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ sv/yuyv_to_rgb_pixel_convert_core.sv @@
// ----------------------------------------------------------------------------
// yuyv_to_rgb_pixel_convert_core
// YUYV macropixel to two 24-bit pixels with programmable chroma gains.
//
// Usage:
//   Drive one macropixel on in_data and raise start; the transfer is taken at
//   that clock edge, since busy is always low. A new macropixel may follow
//   in every cycle, so throughput is one macropixel per clock.
//   The two converted pixels appear on out_data with out_valid high for one
//   cycle, after passing through the input register and then the result
//   register, with the gain products and clamp between them. The receiver
//   cannot stall; each result must be taken in its strobe cycle.
//   The four gains are written over the APB-style port at byte addresses
//   0, 4, 8 and 12 and read back on prdata. Write them only while no
//   conversion is in flight.
//   Reset (rst_n low, synchronous) drops any conversion in flight and
//   restores the default gains 359, 88, 183 and 454.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_pixel_convert_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  yuyv2rgb_pkg::pix_in_t               in_data,
  output logic                                out_valid,
  output yuyv2rgb_pkg::pix_out_t              out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [yuyv2rgb_pkg::ADDR_W-1:0]     paddr,
  input  logic [yuyv2rgb_pkg::DATA_W-1:0]     pwdata,
  output logic [yuyv2rgb_pkg::DATA_W-1:0]     prdata,
  output logic                                pready
);
  import yuyv2rgb_pkg::*;

  coef_set_t coefs;
  logic      in_take;

  assign busy    = 1'b0;
  assign in_take = start & ~busy;

  yuyv2rgb_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  yuyv2rgb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_data   (in_data),
    .coefs     (coefs),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YUYV to RGB pixel converter. A queue of
// macropixels feeds a clocked driver with random start gaps; a clocked
// monitor compares every result strobe field by field against pixel pairs
// predicted at each accepted transfer. The gains are reprogrammed between
// phases (defaults, extremes, mixed, random, with stray upper data bits),
// each phase opening with corner macropixels and then random ones.
// ----------------------------------------------------------------------------
module tb_top;
  import yuyv2rgb_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int STALL_LIMIT = 5000;
  localparam int N_PHASES    = 6;
  localparam int N_CORNERS   = 16;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  pix_in_t             in_data = '0;
  logic                out_valid;
  pix_out_t            out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  coef_set_t           gains;
  pix_in_t             pixel_backlog[$];
  pix_out_t            rgb_expected[$];
  int                  send_idle_pct = 0;
  int                  n_errors = 0;
  int                  stall_cycles = 0;

  yuyv_to_rgb_pixel_convert_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [BYTE_W-1:0] saturate_byte(input int acc);
    if (acc < 0) begin
      return '0;
    end else if (acc >= 65536) begin
      return BYTE_MAX;
    end
    return acc[15:8];
  endfunction

  function automatic pix_out_t predict_pair(input pix_in_t px, input coef_set_t g);
    int cu;
    int cv;
    int y0;
    int y1;
    int red_term;
    int green_term;
    int blue_term;
    pix_out_t res;
    cu = int'(px.chroma_u) - 128;
    cv = int'(px.chroma_v) - 128;
    y0 = int'(px.luma_first) * 256;
    y1 = int'(px.luma_second) * 256;
    red_term   = int'(g.coef_v_red) * cv;
    green_term = int'(g.coef_u_green) * cu + int'(g.coef_v_green) * cv;
    blue_term  = int'(g.coef_u_blue) * cu;
    res.first_px_chan0  = saturate_byte(y0 + red_term);
    res.first_px_green  = saturate_byte(y0 - green_term);
    res.first_px_chan2  = saturate_byte(y0 + blue_term);
    res.second_px_chan0 = saturate_byte(y1 + red_term);
    res.second_px_green = saturate_byte(y1 - green_term);
    res.second_px_chan2 = saturate_byte(y1 + blue_term);
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] random_byte();
    logic [BYTE_W-1:0] corner_vals[4];
    corner_vals = '{8'd0, 8'd255, 8'd127, 8'd128};
    if ($urandom_range(7) == 0) begin
      return corner_vals[$urandom_range(3)];
    end
    return BYTE_W'($urandom_range(255));
  endfunction

  // input transfer: predict on acceptance, then load the next macropixel
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        rgb_expected.push_back(predict_pair(in_data, gains));
      end
      if (!start || !busy) begin
        if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          start   <= 1'b1;
          in_data <= pixel_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result transfer: compare against the oldest prediction
  always @(posedge clk) begin
    pix_out_t want;
    string    field_names[6];
    field_names = '{"first_px_chan0", "first_px_green", "first_px_chan2",
                    "second_px_chan0", "second_px_green", "second_px_chan2"};
    if (rst_n && out_valid) begin
      if (rgb_expected.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
      end else begin
        want = rgb_expected.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (out_data[47 - 8*i -: 8] !== want[47 - 8*i -: 8]) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field_names[i],
                     want[47 - 8*i -: 8], out_data[47 - 8*i -: 8]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_gain(input logic [1:0] reg_idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({reg_idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_idx)
      REG_COEF_V_RED:   gains.coef_v_red   = value[COEF_W-1:0];
      REG_COEF_U_GREEN: gains.coef_u_green = value[COEF_W-1:0];
      REG_COEF_V_GREEN: gains.coef_v_green = value[COEF_W-1:0];
      REG_COEF_U_BLUE:  gains.coef_u_blue  = value[COEF_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pixel_backlog.size() != 0 || start || rgb_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [31:0]       corners[N_CORNERS];
    logic [COEF_W-1:0] phase_gain[4];
    int                idle_plan[N_PHASES];
    int                n_random;
    int                n_corner;
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_FF00, 32'h00FF_00FF,
                32'hFF00_FFFF, 32'h00FF_0000, 32'h8080_8080, 32'h0080_0080,
                32'hFF80_FF80, 32'h7F7F_7F7F, 32'h8181_8181, 32'hAA55_AA55,
                32'h55AA_55AA, 32'h10F0_EB10, 32'hEB10_10F0, 32'h0100_FE01};
    idle_plan = '{26, 26, 58, 58, 0, 0};
    gains = '{RST_COEF_V_RED, RST_COEF_U_GREEN, RST_COEF_V_GREEN, RST_COEF_U_BLUE};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: phase_gain = '{RST_COEF_V_RED, RST_COEF_U_GREEN, RST_COEF_V_GREEN, RST_COEF_U_BLUE};
        1: phase_gain = '{10'd1023, 10'd1023, 10'd1023, 10'd1023};
        2: phase_gain = '{10'd0, 10'd0, 10'd0, 10'd0};
        3: phase_gain = '{10'd1023, 10'd0, 10'd1023, 10'd0};
        4: phase_gain = '{10'd0, 10'd1023, 10'd0, 10'd1023};
        default: begin
          for (int r = 0; r < 4; r++) begin
            phase_gain[r] = COEF_W'($urandom_range(1023));
          end
        end
      endcase
      if (ph != 0) begin
        for (int r = 0; r < 4; r++) begin
          write_gain(2'(r), {22'($urandom_range((1 << 22) - 1)), phase_gain[r]});
        end
      end
      send_idle_pct = idle_plan[ph];
      n_corner = (ph == 0) ? N_CORNERS : 4;
      for (int k = 0; k < n_corner; k++) begin
        pixel_backlog.push_back(pix_in_t'(corners[k]));
      end
      n_random = 240;
      for (int k = 0; k < n_random; k++) begin
        pixel_backlog.push_back('{random_byte(), random_byte(), random_byte(), random_byte()});
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (n_errors == 0 && rgb_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0t: %0d mismatches, %0d results outstanding", $time, n_errors,
               rgb_expected.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
